// File: hdl/cosine_similarity_stream_core_assert.svh
// ----------------------------------------------------------------------------
// Cosine similarity stream core assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_STREAM_CORE_ASSERT_SVH
`define COSINE_SIMILARITY_STREAM_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CSSC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cssc: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define CSSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cssc: next-cycle check failed");

`endif

// File: hdl/cssc_pkg.sv
// ----------------------------------------------------------------------------
// Cosine similarity stream package
// Widths, queue sizing and shared types of the cosine similarity core.
// ----------------------------------------------------------------------------
package cssc_pkg;

   // Element format: signed Q1.15.
   localparam int ELEM_W = 16;
   localparam int FRAC   = 15;

   // Longest vector that is summed; later pairs are dropped and flagged.
   localparam int MAX_LEN = 1024;
   localparam int LEN_W   = $clog2(MAX_LEN + 1);

   // Square of one element is at most 2^30 and needs one bit less than a product.
   localparam int ESQ_W  = 2 * ELEM_W - 1;
   // Accumulated squared norm and signed dot product.
   localparam int NORM_W = 2 * FRAC + $clog2(MAX_LEN) + 1;
   localparam int DOT_W  = NORM_W + 1;

   // Back end widths: products of two sums, scaled numerator, quotient.
   localparam int SQ_W     = 2 * NORM_W;
   localparam int SCALE_SH = 2 * FRAC;
   localparam int NUM_W    = SQ_W + SCALE_SH;
   localparam int QUO_W    = SCALE_SH + 1;
   localparam int CNT_W    = $clog2(NORM_W);

   // Queue of finished sums between front and back (power of two deep).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   // Sums of one finished vector.
   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [NORM_W-1:0]       norm_a;
      logic [NORM_W-1:0]       norm_b;
      logic                    overflow;
   } vec_sums_type;

   // Fill state of the queue.
   typedef struct packed {
      logic              not_empty;
      logic [QLVL_W-1:0] level;
   } queue_status_type;

endpackage

// File: hdl/cssc_front.sv
// ----------------------------------------------------------------------------
// Cosine similarity front end
// Takes element pairs, counts them against the length limit and keeps the
// dot product and squared norm sums; a last pair hands the sums to the queue.
// ----------------------------------------------------------------------------
module cssc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [cssc_pkg::ELEM_W-1:0]  req_elem_a,
   input  logic signed [cssc_pkg::ELEM_W-1:0]  req_elem_b,
   input  logic                                req_last_pair,
   input  cssc_pkg::queue_status_type          q_status,
   output logic                                push,
   output cssc_pkg::vec_sums_type              push_entry
);
   import cssc_pkg::*;

   logic                      accept;
   logic                      in_range;
   logic [LEN_W-1:0]          cnt_ff, cnt_in;
   logic                      ovf_ff, ovf_in;
   logic signed [2*ELEM_W-1:0] prod_ab, prod_aa, prod_bb;

   logic                      p_valid_ff, p_valid_in;
   logic                      p_last_ff;
   logic                      p_ovf_ff;
   logic signed [2*ELEM_W-1:0] p_ab_ff;
   logic [ESQ_W-1:0]          p_aa_ff;
   logic [ESQ_W-1:0]          p_bb_ff;

   logic signed [DOT_W-1:0]   dot_ff, dot_in, dot_new;
   logic [NORM_W-1:0]         na_ff, na_in, na_new;
   logic [NORM_W-1:0]         nb_ff, nb_in, nb_new;
   logic [QLVL_W-1:0]         reserved;

   // Stall when the queue plus a last pair still in flight would fill it.
   assign reserved  = q_status.level + QLVL_W'(p_valid_ff & p_last_ff);
   assign req_stall = (reserved >= QLVL_W'(QUEUE_DEPTH));
   assign accept    = req_valid & ~req_stall;

   // Pairs are summed only while the count is below the limit.
   assign in_range = (cnt_ff < LEN_W'(MAX_LEN));

   always_comb begin
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_last_pair) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = in_range ? cnt_ff + LEN_W'(1) : cnt_ff;
            ovf_in = ovf_ff | ~in_range;
         end
      end
   end

   // Element products, registered before accumulation.
   assign prod_ab = req_elem_a * req_elem_b;
   assign prod_aa = req_elem_a * req_elem_a;
   assign prod_bb = req_elem_b * req_elem_b;
   assign p_valid_in = accept;

   // Accumulate the registered products and close the vector on a last pair.
   assign dot_new = dot_ff + DOT_W'(p_ab_ff);
   assign na_new  = na_ff + NORM_W'(p_aa_ff);
   assign nb_new  = nb_ff + NORM_W'(p_bb_ff);

   always_comb begin
      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      if (p_valid_ff) begin
         if (p_last_ff) begin
            dot_in = '0;
            na_in  = '0;
            nb_in  = '0;
         end else begin
            dot_in = dot_new;
            na_in  = na_new;
            nb_in  = nb_new;
         end
      end
   end

   assign push                = p_valid_ff & p_last_ff;
   assign push_entry.dot      = dot_new;
   assign push_entry.norm_a   = na_new;
   assign push_entry.norm_b   = nb_new;
   assign push_entry.overflow = p_ovf_ff;

   // Control state and running sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         p_valid_ff <= 1'b0;
         dot_ff     <= '0;
         na_ff      <= '0;
         nb_ff      <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         p_valid_ff <= p_valid_in;
         dot_ff     <= dot_in;
         na_ff      <= na_in;
         nb_ff      <= nb_in;
      end
   end

   // Product stage; dropped pairs contribute zero.
   always_ff @(posedge clock) begin
      if (accept) begin
         p_last_ff <= req_last_pair;
         p_ovf_ff  <= ovf_ff | ~in_range;
         p_ab_ff   <= in_range ? prod_ab : '0;
         p_aa_ff   <= in_range ? prod_aa[ESQ_W-1:0] : '0;
         p_bb_ff   <= in_range ? prod_bb[ESQ_W-1:0] : '0;
      end
   end

endmodule

// File: hdl/cssc_queue.sv
// ----------------------------------------------------------------------------
// Cosine similarity sums queue
// Short FIFO of finished vector sums between the front and back ends.
// ----------------------------------------------------------------------------
module cssc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cssc_pkg::vec_sums_type      push_entry,
   input  logic                        pop,
   output cssc_pkg::vec_sums_type      head,
   output cssc_pkg::queue_status_type  status
);
   import cssc_pkg::*;

   vec_sums_type       entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0]  level_ff, level_in;

   // Pointer and fill level bookkeeping.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + QLVL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QLVL_W'(1);
      end
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign status.level     = level_ff;
   assign status.not_empty = (level_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: hdl/cssc_back.sv
// ----------------------------------------------------------------------------
// Cosine similarity back end
// Serial engine that turns one vector's sums into the clamped Q1.15 ratio:
// shift-add squaring, restoring division and a bitwise square root.
// ----------------------------------------------------------------------------
module cssc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  cssc_pkg::vec_sums_type              head,
   input  cssc_pkg::queue_status_type          q_status,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cssc_pkg::ELEM_W-1:0]  rsp_similarity,
   output logic                                rsp_zero_norm,
   output logic                                rsp_length_overflow
);
   import cssc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_ROOT = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic                     out_valid_ff, out_valid_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   logic [SQ_W-1:0]          mcand_m_ff, mcand_m_in, acc_m_ff, acc_m_in;
   logic [SQ_W-1:0]          mcand_p_ff, mcand_p_in, acc_p_ff, acc_p_in;
   logic [NORM_W-1:0]        mplier_m_ff, mplier_m_in;
   logic [NORM_W-1:0]        mplier_p_ff, mplier_p_in;
   logic [NUM_W-1:0]         rem_ff, rem_in, div_ff, div_in;
   logic [QUO_W-1:0]         quo_ff, quo_in;
   logic [FRAC-1:0]          root_ff, root_in, bit_ff, bit_in, cand;
   logic [2*FRAC-1:0]        cand_sq;
   logic signed [ELEM_W-1:0] sim_ff, sim_in;
   logic                     zero_ff, zero_in;
   logic                     ovf_ff, ovf_in;
   logic signed [DOT_W-1:0]  dot_abs;
   logic [NORM_W-1:0]        mag;

   // Magnitude of the dot product fits the norm width by Cauchy-Schwarz.
   assign dot_abs = head.dot[DOT_W-1] ? -head.dot : head.dot;
   assign mag     = dot_abs[NORM_W-1:0];

   // Candidate root bit and its square.
   assign cand    = root_ff | bit_ff;
   assign cand_sq = {{FRAC{1'b0}}, cand} * {{FRAC{1'b0}}, cand};

   // Sequencer: largest q below 2^15 with q^2 <= floor(dot^2 * 2^30 / (na * nb)).
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      mcand_m_in   = mcand_m_ff;
      mcand_p_in   = mcand_p_ff;
      mplier_m_in  = mplier_m_ff;
      mplier_p_in  = mplier_p_ff;
      acc_m_in     = acc_m_ff;
      acc_p_in     = acc_p_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      sim_in       = sim_ff;
      zero_in      = zero_ff;
      ovf_in       = ovf_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop    = 1'b1;
               neg_in = head.dot[DOT_W-1];
               ovf_in = head.overflow;
               if (head.norm_a == '0 || head.norm_b == '0) begin
                  sim_in       = '0;
                  zero_in      = 1'b1;
                  out_valid_in = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  zero_in     = 1'b0;
                  mcand_m_in  = SQ_W'(mag);
                  mplier_m_in = mag;
                  mcand_p_in  = SQ_W'(head.norm_a);
                  mplier_p_in = head.norm_b;
                  acc_m_in    = '0;
                  acc_p_in    = '0;
                  cnt_in      = CNT_W'(NORM_W - 1);
                  state_in    = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // Both products advance one multiplier bit per cycle.
            if (mplier_m_ff[0]) begin
               acc_m_in = acc_m_ff + mcand_m_ff;
            end
            if (mplier_p_ff[0]) begin
               acc_p_in = acc_p_ff + mcand_p_ff;
            end
            mcand_m_in  = {mcand_m_ff[SQ_W-2:0], 1'b0};
            mcand_p_in  = {mcand_p_ff[SQ_W-2:0], 1'b0};
            mplier_m_in = {1'b0, mplier_m_ff[NORM_W-1:1]};
            mplier_p_in = {1'b0, mplier_p_ff[NORM_W-1:1]};
            if (cnt_ff == '0) begin
               rem_in   = {acc_m_in, {SCALE_SH{1'b0}}};
               div_in   = {acc_p_in, {SCALE_SH{1'b0}}};
               quo_in   = '0;
               cnt_in   = CNT_W'(QUO_W - 1);
               state_in = ST_DIV;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle; the quotient never exceeds 2^30.
            if (rem_ff >= div_ff) begin
               rem_in = rem_ff - div_ff;
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            div_in = {1'b0, div_ff[NUM_W-1:1]};
            if (cnt_ff == '0) begin
               root_in  = '0;
               bit_in   = {1'b1, {(FRAC-1){1'b0}}};
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         ST_ROOT: begin
            // Root bits from the top; stopping below 2^15 gives the clamp.
            if ({1'b0, cand_sq} <= quo_ff) begin
               root_in = cand;
            end
            bit_in = {1'b0, bit_ff[FRAC-1:1]};
            if (bit_ff[0]) begin
               sim_in       = neg_ff ? -{1'b0, root_in} : {1'b0, root_in};
               out_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               out_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            out_valid_in = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_similarity      = sim_ff;
   assign rsp_zero_norm       = zero_ff;
   assign rsp_length_overflow = ovf_ff;

   // Sequencer control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      mcand_m_ff  <= mcand_m_in;
      mcand_p_ff  <= mcand_p_in;
      mplier_m_ff <= mplier_m_in;
      mplier_p_ff <= mplier_p_in;
      acc_m_ff    <= acc_m_in;
      acc_p_ff    <= acc_p_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      root_ff     <= root_in;
      bit_ff      <= bit_in;
      sim_ff      <= sim_in;
      zero_ff     <= zero_in;
      ovf_ff      <= ovf_in;
   end

endmodule

// File: hdl/cosine_similarity_stream_core.sv
// ----------------------------------------------------------------------------
// Cosine similarity stream core
// Streams two Q1.15 vectors pair by pair and returns their cosine similarity.
// ----------------------------------------------------------------------------
// The input side takes one element pair per cycle unless req_stall holds it;
// sums are kept in a two stage multiply-accumulate front end. A pair marked
// last closes the vector and its sums go to a two-entry queue, and one
// transaction per vector comes out: similarity truncated toward zero and
// clamped to +/-32767, a zero-norm flag (similarity 0) and a length-overflow
// flag when more than MAX_LEN pairs arrived. The back end is one serial unit:
// per vector it runs 41 shift-add squaring steps, 31 divide steps and 15 root
// steps between load and output, none for a zero-norm vector. Vectors longer than that work
// stream without a stall; shorter ones stall the input once the queue is full.
module cosine_similarity_stream_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [cssc_pkg::ELEM_W-1:0]  req_elem_a,
   input  logic signed [cssc_pkg::ELEM_W-1:0]  req_elem_b,
   input  logic                                req_last_pair,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cssc_pkg::ELEM_W-1:0]  rsp_similarity,
   output logic                                rsp_zero_norm,
   output logic                                rsp_length_overflow
);
   import cssc_pkg::*;

`include "cosine_similarity_stream_core_assert.svh"

   logic             push;
   logic             pop;
   vec_sums_type     push_entry;
   vec_sums_type     head;
   queue_status_type q_status;

   // Front end: pair intake and accumulation.
   cssc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_elem_a    (req_elem_a),
      .req_elem_b    (req_elem_b),
      .req_last_pair (req_last_pair),
      .q_status      (q_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   // Queue of finished vector sums.
   cssc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // Back end: ratio and square root engine with the result register.
   cssc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_status            (q_status),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_similarity      (rsp_similarity),
      .rsp_zero_norm       (rsp_zero_norm),
      .rsp_length_overflow (rsp_length_overflow)
   );

   // Checks on queue flow control and result encoding.
   `CSSC_ASSERT_SAME(a_push_has_room, clock, reset, push, q_status.level < QLVL_W'(QUEUE_DEPTH))
   `CSSC_ASSERT_NEXT(a_push_lands, clock, reset, push, q_status.not_empty)
   `CSSC_ASSERT_SAME(a_zero_norm_result, clock, reset, rsp_valid && rsp_zero_norm, rsp_similarity == '0)
   `CSSC_ASSERT_SAME(a_similarity_clamped, clock, reset, rsp_valid, rsp_similarity != {1'b1, {(ELEM_W-1){1'b0}}})

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Cosine similarity stream core testbench
// Streams element pairs into the core under several idle and stall patterns,
// predicts every similarity transaction in exact integer arithmetic, and
// checks each result field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
   import cssc_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TAIL_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 160;
   localparam int PHASES       = 4;

   // One element pair as it is offered to the core.
   typedef struct {
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      logic                     is_last;
   } elem_pair_type;

   // One predicted similarity transaction.
   typedef struct {
      logic signed [ELEM_W-1:0] similarity;
      logic                     zero_norm;
      logic                     length_overflow;
   } sim_result_type;

   // Shapes of random vectors.
   typedef enum int {
      VK_RANDOM,
      VK_SAME,
      VK_NEGATED,
      VK_SCALED,
      VK_SMALL,
      VK_ZERO_SIDE,
      VK_SPARSE
   } vec_kind_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic signed [ELEM_W-1:0] req_elem_a = '0;
   logic signed [ELEM_W-1:0] req_elem_b = '0;
   logic                     req_last_pair = 1'b0;
   logic                     rsp_stall = 1'b0;
   logic                     req_stall;
   logic                     rsp_valid;
   logic signed [ELEM_W-1:0] rsp_similarity;
   logic                     rsp_zero_norm;
   logic                     rsp_length_overflow;

   elem_pair_type  pending_pairs[$];
   sim_result_type expected_sims[$];

   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   logic req_taken      = 1'b0;

   // Predicted accumulator state of the vector in progress.
   longint          dot_acc       = 0;
   longint unsigned norm_a_acc    = 0;
   longint unsigned norm_b_acc    = 0;
   int              pairs_taken   = 0;
   logic            overflow_flag = 1'b0;

   int send_pct_tab[PHASES] = '{76, 0, 14, 0};
   int recv_pct_tab[PHASES] = '{0, 76, 14, 0};

   cosine_similarity_stream_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_elem_a          (req_elem_a),
      .req_elem_b          (req_elem_b),
      .req_last_pair       (req_last_pair),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_similarity      (rsp_similarity),
      .rsp_zero_norm       (rsp_zero_norm),
      .rsp_length_overflow (rsp_length_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Largest q up to 32767 with q*q*na*nb <= mag*mag*2^30, found bit by bit.
   function automatic logic [FRAC-1:0] q15_ratio(input longint unsigned mag,
                                                 input longint unsigned na,
                                                 input longint unsigned nb);
      logic [127:0]    mag_w;
      logic [127:0]    na_w;
      logic [127:0]    nb_w;
      logic [127:0]    scaled_dot_sq;
      logic [127:0]    norm_prod;
      logic [127:0]    cand;
      logic [127:0]    lhs;
      logic [FRAC-1:0] q;
      mag_w = 128'(mag);
      na_w = 128'(na);
      nb_w = 128'(nb);
      scaled_dot_sq = (mag_w * mag_w) << 30;
      norm_prod = na_w * nb_w;
      q = '0;
      for (int i = FRAC - 1; i >= 0; i--) begin
         cand = 128'(q);
         cand = cand | (128'd1 << i);
         lhs = cand * cand * norm_prod;
         if (lhs <= scaled_dot_sq) begin
            q = cand[FRAC-1:0];
         end
      end
      return q;
   endfunction

   // Accumulates one accepted pair and predicts the transaction a last pair causes.
   task automatic take_pair(input logic signed [ELEM_W-1:0] a,
                            input logic signed [ELEM_W-1:0] b,
                            input logic is_last);
      sim_result_type  res;
      longint          mag;
      logic [FRAC-1:0] q;
      if (pairs_taken < MAX_LEN) begin
         dot_acc += longint'(a) * longint'(b);
         norm_a_acc += longint'(a) * longint'(a);
         norm_b_acc += longint'(b) * longint'(b);
         pairs_taken++;
      end else begin
         overflow_flag = 1'b1;
      end
      if (is_last) begin
         if (norm_a_acc == 0 || norm_b_acc == 0) begin
            res.similarity = '0;
            res.zero_norm = 1'b1;
         end else begin
            mag = (dot_acc < 0) ? -dot_acc : dot_acc;
            q = q15_ratio(mag, norm_a_acc, norm_b_acc);
            res.similarity = {1'b0, q};
            if (dot_acc < 0) begin
               res.similarity = -res.similarity;
            end
            res.zero_norm = 1'b0;
         end
         res.length_overflow = overflow_flag;
         expected_sims.insert(expected_sims.size(), res);
         dot_acc = 0;
         norm_a_acc = 0;
         norm_b_acc = 0;
         pairs_taken = 0;
         overflow_flag = 1'b0;
      end
   endtask

   task automatic queue_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic is_last);
      elem_pair_type p;
      p.a = a;
      p.b = b;
      p.is_last = is_last;
      pending_pairs.insert(pending_pairs.size(), p);
   endtask

   // Full-range element with the extremes and the values near zero favored.
   function automatic logic signed [ELEM_W-1:0] rand_elem();
      int r;
      r = $urandom_range(19);
      if (r == 0) return -16'sd32768;
      else if (r == 1) return 16'sd32767;
      else if (r == 2) return 16'sd0;
      else if (r == 3) return -16'sd1;
      else if (r == 4) return 16'sd1;
      else return ELEM_W'($urandom());
   endfunction

   // Mostly short vectors, a few longer ones.
   function automatic int rand_length();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(8, 1);
      else return $urandom_range(40, 9);
   endfunction

   // Queues one whole vector of the given length with a randomly chosen shape.
   task automatic gen_vector(input int len);
      vec_kind_type             kind;
      int                       r;
      int                       shift;
      int                       tmp;
      logic signed [ELEM_W-1:0] a;
      logic signed [ELEM_W-1:0] b;
      r = $urandom_range(9);
      kind = (r < 4) ? VK_RANDOM : vec_kind_type'(r - 3);
      shift = $urandom_range(3);
      for (int k = 0; k < len; k++) begin
         a = rand_elem();
         b = rand_elem();
         case (kind)
            VK_SAME: begin
               b = a;
            end
            VK_NEGATED: begin
               b = -a;
            end
            VK_SCALED: begin
               b = a >>> shift;
            end
            VK_SMALL: begin
               tmp = $urandom_range(255);
               a = ELEM_W'(tmp - 128);
               tmp = $urandom_range(255);
               b = ELEM_W'(tmp - 128);
            end
            VK_ZERO_SIDE: begin
               if (shift[0]) a = '0;
               else b = '0;
            end
            VK_SPARSE: begin
               if ($urandom_range(1)) a = '0;
               if ($urandom_range(1)) b = '0;
            end
            default: begin
            end
         endcase
         queue_pair(a, b, k == len - 1);
      end
   endtask

   // Driver: offers the next pending pair once the previous transaction is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_elem_a <= pending_pairs[0].a;
            req_elem_b <= pending_pairs[0].b;
            req_last_pair <= pending_pairs[0].is_last;
            pending_pairs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stalls the result channel at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Monitor: checks each result transaction, then feeds accepted pairs to the predictor.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sims.size() == 0) begin
               $error("unexpected result: similarity %0d", rsp_similarity);
               mismatches = mismatches + 1;
            end else begin
               if (rsp_similarity !== expected_sims[0].similarity) begin
                  $error("similarity mismatch: expected %0d, actual %0d",
                         expected_sims[0].similarity, rsp_similarity);
                  mismatches = mismatches + 1;
               end
               if (rsp_zero_norm !== expected_sims[0].zero_norm) begin
                  $error("zero_norm mismatch: expected %0d, actual %0d",
                         expected_sims[0].zero_norm, rsp_zero_norm);
                  mismatches = mismatches + 1;
               end
               if (rsp_length_overflow !== expected_sims[0].length_overflow) begin
                  $error("length_overflow mismatch: expected %0d, actual %0d",
                         expected_sims[0].length_overflow, rsp_length_overflow);
                  mismatches = mismatches + 1;
               end
               expected_sims.pop_front();
            end
         end
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            take_pair(req_elem_a, req_elem_b, req_last_pair);
         end
      end
   end

   // Stimulus sequence and end of run.
   initial begin
      int pushed;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed vectors: parallel and antiparallel extremes, zero norms,
      // orthogonal vectors and the smallest magnitudes.
      queue_pair(16'sd32767, 16'sd32767, 1'b1);
      queue_pair(-16'sd32768, -16'sd32768, 1'b1);
      queue_pair(-16'sd32768, 16'sd32767, 1'b1);
      queue_pair(16'sd0, 16'sd5, 1'b1);
      queue_pair(16'sd7, 16'sd0, 1'b1);
      queue_pair(16'sd0, 16'sd0, 1'b0);
      queue_pair(16'sd0, 16'sd0, 1'b1);
      queue_pair(16'sd100, 16'sd0, 1'b0);
      queue_pair(16'sd0, 16'sd100, 1'b1);
      queue_pair(16'sd1, -16'sd1, 1'b1);
      queue_pair(-16'sd1, -16'sd1, 1'b1);
      queue_pair(16'sd1, 16'sd1, 1'b0);
      queue_pair(-16'sd32768, 16'sd32767, 1'b0);
      queue_pair(16'sd32767, -16'sd32768, 1'b0);
      queue_pair(16'sd12345, -16'sd2222, 1'b1);

      // MAX_LEN full-scale pairs fill the sums to their limit; the extra
      // pairs after them, the last-marked one included, are dropped.
      for (int k = 0; k < MAX_LEN + 3; k++) begin
         if (k < MAX_LEN) begin
            queue_pair(-16'sd32768, -16'sd32768, 1'b0);
         end else begin
            queue_pair(rand_elem(), rand_elem(), k == MAX_LEN + 2);
         end
      end
      // A short vector right after shows that the overflow mark was cleared.
      queue_pair(16'sd3, 16'sd4, 1'b1);
      while (pending_pairs.size() != 0) @(posedge clock);

      // Random vectors under each idle and stall pattern.
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = send_pct_tab[p];
         recv_stall_pct = recv_pct_tab[p];
         pushed = 0;
         while (pushed < RANDOM_ITEMS / PHASES) begin
            int len;
            len = rand_length();
            gen_vector(len);
            pushed += len;
         end
         while (pending_pairs.size() != 0) @(posedge clock);
      end

      // Drain: every pair accepted, every result arrived, then a quiet tail.
      while (pending_pairs.size() != 0 || req_valid) @(posedge clock);
      while (expected_sims.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_sims.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
